// ===== hdl/lstk_pkg.sv =====
`default_nettype none

package lstk_pkg;

   // Default sizing of the stack.
   localparam int STACK_DEPTH_DEF = 64;
   localparam int WORD_BITS_DEF   = 32;

   // Fixed widths of the channel fields.
   localparam int VALUE_W = 32;
   localparam int FIELD_W = 7;

   typedef enum logic [1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_POP    = 2'd1,
      FUNC_SEARCH = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   // Commands broadcast to every cell of the chain.
   typedef struct packed {
      logic shift_down;   // push: every word moves one cell away from the top
      logic shift_up;     // pop: every word moves one cell toward the top
      logic rotate;       // search: move up, the top word wraps to the last entry
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/lstk_if.sv =====
`default_nettype none

interface lstk_req_if;
   logic                                  valid;
   logic                                  ready;
   lstk_pkg::func_type                    func;
   logic signed [lstk_pkg::VALUE_W-1:0]   value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface lstk_rsp_if;
   logic                                  valid;
   logic                                  ready;
   lstk_pkg::status_type                  status;
   logic [lstk_pkg::FIELD_W-1:0]          position;
   logic [lstk_pkg::FIELD_W-1:0]          entry_count;

   modport source (output valid, output status, output position, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input position, input entry_count,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/lstk_cell.sv =====
`default_nettype none

// One stack entry. Cell 0 holds the top of the stack.
module lstk_cell #(
   parameter int STACK_DEPTH = lstk_pkg::STACK_DEPTH_DEF,
   parameter int WORD_BITS   = lstk_pkg::WORD_BITS_DEF,
   parameter int INDEX       = 0
) (
   input  wire                          clock,
   input  lstk_pkg::cell_ctrl_type      ctrl,
   input  wire [$clog2(STACK_DEPTH)-1:0] last_idx,
   input  wire [WORD_BITS-1:0]          above_word,
   input  wire [WORD_BITS-1:0]          below_word,
   input  wire [WORD_BITS-1:0]          top_word,
   output logic [WORD_BITS-1:0]         word_out
);

   localparam int IDX_W = $clog2(STACK_DEPTH);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;
   logic                 is_last;

   assign is_last = (last_idx == IDX_W'(INDEX));

   always_comb begin
      word_in = word_ff;
      if (ctrl.shift_down) begin
         word_in = above_word;
      end else if (ctrl.shift_up) begin
         word_in = below_word;
      end else if (ctrl.rotate) begin
         word_in = is_last ? top_word : below_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

`default_nettype wire

// ===== hdl/lifo_stack_with_search_core.sv =====
// Push, pop, clear and a search on an empty stack give their result in the cycle after
// the transfer; a new item can be taken every cycle for them while the response is taken.
// A search over N entries (N up to STACK_DEPTH) rotates them through the cell chain, one
// per cycle past the compare at the top cell, and gives its result with the stack back in
// its original order; the next item waits until that result is given.
// Reset clears the entry count, the state machine and the response valid, not the words.
`default_nettype none

module lifo_stack_with_search_core #(
   parameter int STACK_DEPTH = lstk_pkg::STACK_DEPTH_DEF,
   parameter int WORD_BITS   = lstk_pkg::WORD_BITS_DEF
) (
   input  wire               clock,
   input  wire               reset,
   lstk_req_if.sink          req,
   lstk_rsp_if.source        rsp
);

   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   state_type                      state_ff;
   logic [CNT_W-1:0]               count_ff;
   logic [CNT_W-1:0]               step_ff;
   logic [CNT_W-1:0]               pos_ff;
   logic                           found_ff;
   logic [WORD_BITS-1:0]           key_ff;

   logic                           rsp_valid_ff;
   lstk_pkg::status_type           status_ff;
   logic [lstk_pkg::FIELD_W-1:0]   position_ff;
   logic [lstk_pkg::FIELD_W-1:0]   entry_count_ff;

   lstk_pkg::cell_ctrl_type        ctrl;
   logic [WORD_BITS-1:0]           new_word;
   logic [WORD_BITS-1:0]           cell_words [STACK_DEPTH];
   logic [IDX_W-1:0]               last_idx;
   logic                           req_transfer;
   logic                           hit;
   logic                           is_full;
   logic                           is_empty;
   logic                           last_step;
   logic                           rsp_load;

   // The signed input is sign-extended (or cut) to the stored word width.
   assign new_word = WORD_BITS'(req.value);

   // A new item is taken only when no search runs and the response register is free.
   assign req.ready    = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign req_transfer = req.valid && req.ready;

   assign is_full   = (count_ff == CNT_W'(STACK_DEPTH));
   assign is_empty  = (count_ff == '0);
   assign last_idx  = IDX_W'(count_ff - CNT_W'(1));
   assign last_step = (step_ff == count_ff - CNT_W'(1));
   assign hit       = (cell_words[0] == key_ff);

   // A result is loaded at the transfer of every operation except a search that has
   // entries to scan, and at the last step of such a search.
   assign rsp_load = (req_transfer && !(req.func == lstk_pkg::FUNC_SEARCH && !is_empty))
                     || (state_ff == ST_SEARCH && last_step);

   // Commands for the cell chain. Push and pop move the whole chain in the cycle of
   // the transfer; a search rotates the valid entries once per cycle.
   always_comb begin
      ctrl = '0;
      if (req_transfer) begin
         case (req.func)
            lstk_pkg::FUNC_PUSH: ctrl.shift_down = !is_full;
            lstk_pkg::FUNC_POP:  ctrl.shift_up   = !is_empty;
            default:             ctrl            = '0;
         endcase
      end
      if (state_ff == ST_SEARCH) begin
         ctrl.rotate = 1'b1;
      end
   end

   // The chain of cells. Cell 0 is the top of the stack and takes the pushed word; the
   // bottom cell refills from itself on a pop, which only touches an invalid entry.
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [WORD_BITS-1:0] above;
      logic [WORD_BITS-1:0] below;

      if (i == 0) begin : g_top
         assign above = new_word;
      end else begin : g_mid_above
         assign above = cell_words[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below = cell_words[i];
      end else begin : g_mid_below
         assign below = cell_words[i+1];
      end

      lstk_cell #(
         .STACK_DEPTH (STACK_DEPTH),
         .WORD_BITS   (WORD_BITS),
         .INDEX       (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .last_idx   (last_idx),
         .above_word (above),
         .below_word (below),
         .top_word   (cell_words[0]),
         .word_out   (cell_words[i])
      );
   end

   // Control state and the response register. During a search the entry at the top
   // cell in step k is the entry at position k+1 from the top; the first hit wins.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         pos_ff       <= '0;
         found_ff     <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_transfer) begin
                  position_ff <= '0;
                  case (req.func)
                     lstk_pkg::FUNC_PUSH: begin
                        if (is_full) begin
                           status_ff      <= lstk_pkg::STATUS_FULL;
                           entry_count_ff <= lstk_pkg::FIELD_W'(count_ff);
                        end else begin
                           status_ff      <= lstk_pkg::STATUS_OK;
                           count_ff       <= count_ff + CNT_W'(1);
                           entry_count_ff <= lstk_pkg::FIELD_W'(count_ff + CNT_W'(1));
                        end
                     end
                     lstk_pkg::FUNC_POP: begin
                        if (is_empty) begin
                           status_ff      <= lstk_pkg::STATUS_EMPTY;
                           entry_count_ff <= '0;
                        end else begin
                           status_ff      <= lstk_pkg::STATUS_OK;
                           count_ff       <= count_ff - CNT_W'(1);
                           entry_count_ff <= lstk_pkg::FIELD_W'(count_ff - CNT_W'(1));
                        end
                     end
                     lstk_pkg::FUNC_SEARCH: begin
                        entry_count_ff <= lstk_pkg::FIELD_W'(count_ff);
                        if (is_empty) begin
                           status_ff    <= lstk_pkg::STATUS_EMPTY;
                        end else begin
                           state_ff <= ST_SEARCH;
                           key_ff   <= new_word;
                           step_ff  <= '0;
                           pos_ff   <= '0;
                           found_ff <= 1'b0;
                        end
                     end
                     default: begin
                        count_ff       <= '0;
                        entry_count_ff <= '0;
                        status_ff      <= is_empty ? lstk_pkg::STATUS_EMPTY
                                                   : lstk_pkg::STATUS_OK;
                     end
                  endcase
               end
            end
            ST_SEARCH: begin
               step_ff <= step_ff + CNT_W'(1);
               if (hit && !found_ff) begin
                  found_ff <= 1'b1;
                  pos_ff   <= step_ff + CNT_W'(1);
               end
               if (last_step) begin
                  state_ff     <= ST_IDLE;
                  if (found_ff) begin
                     status_ff   <= lstk_pkg::STATUS_OK;
                     position_ff <= lstk_pkg::FIELD_W'(pos_ff);
                  end else if (hit) begin
                     status_ff   <= lstk_pkg::STATUS_OK;
                     position_ff <= lstk_pkg::FIELD_W'(step_ff + CNT_W'(1));
                  end else begin
                     status_ff   <= lstk_pkg::STATUS_NOT_FOUND;
                     position_ff <= '0;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.position    = position_ff;
   assign rsp.entry_count = entry_count_ff;

endmodule

`default_nettype wire
